FILE: design/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs clk and arst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while in reset.
`define PSD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Plain invariant.
`define PSD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

FILE: design/psd_pkg.sv
// Package for the point to segment distance pipeline.
// Default coordinate width and region codes; no dependencies.
`default_nettype none

package psd_pkg;

	localparam int COORD_BITS_DEF = 16;

	localparam logic [1:0] REGION_START = 2'd0;
	localparam logic [1:0] REGION_END   = 2'd1;
	localparam logic [1:0] REGION_PERP  = 2'd2;

endpackage

`default_nettype wire

FILE: design/point_segment_distance.sv
// Point to segment distance, fully pipelined.
// Uses psd_pkg and assert_macros.svh.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------
//  in       | start / busy       | px py ax ay bx by
//  out      | strobe (no stall)  | distance region
//
//  One item enters per cycle; busy is never raised.
//  Results come out in input order after the differences, products, region,
//  cross squared and dividend stages, then the divider with one quotient bit
//  per stage and the square root with one root bit per stage.
//  Reset clears only the valid bits; nothing in flight survives it.
//  The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module point_segment_distance #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] px,
	input  wire logic signed [COORD_BITS-1:0] py,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by,
	output logic                              strobe,
	output logic [COORD_BITS:0]               distance,
	output logic [1:0]                        region
);
	import psd_pkg::*;

	`include "assert_macros.svh"

	localparam int DIFW = COORD_BITS + 1;         // coordinate differences
	localparam int PRDW = 2 * DIFW;               // signed products
	localparam int DOTW = PRDW + 1;               // sums of two products
	localparam int SQW  = 2 * COORD_BITS;         // one square
	localparam int CW   = 2 * COORD_BITS + 1;     // |cross|, sum of squares
	localparam int QW   = CW;                     // squared distance
	localparam int DW   = CW;                     // divisor |B-A|^2
	localparam int NW   = 2 * CW;                 // dividend cross^2
	localparam int RW   = COORD_BITS + 1;         // root bits
	localparam int TW   = QW + 1;                 // root trial width
	localparam int H    = (CW + 1) / 2;           // split point of cross
	localparam int HW   = CW - H;
	localparam int LAT  = 5 + QW + RW;

	assign busy = 1'b0;

	// ---- stage 1: differences
	logic                   vld_s1;
	logic signed [DIFW-1:0] ex_s1, ey_s1, ux_s1, uy_s1, vx_s1, vy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		ex_s1 <= DIFW'(bx) - DIFW'(ax);
		ey_s1 <= DIFW'(by) - DIFW'(ay);
		ux_s1 <= DIFW'(px) - DIFW'(ax);
		uy_s1 <= DIFW'(py) - DIFW'(ay);
		vx_s1 <= DIFW'(px) - DIFW'(bx);
		vy_s1 <= DIFW'(py) - DIFW'(by);
	end

	// ---- stage 2: products
	logic                   vld_s2, degen_s2;
	logic signed [PRDW-1:0] uex_s2, uey_s2, vex_s2, vey_s2, cxy_s2, cyx_s2;
	logic [SQW-1:0]         sux_s2, suy_s2, svx_s2, svy_s2, sex_s2, sey_s2;
	logic signed [PRDW-1:0] sq_ux, sq_uy, sq_vx, sq_vy, sq_ex, sq_ey;

	assign sq_ux = ux_s1 * ux_s1;
	assign sq_uy = uy_s1 * uy_s1;
	assign sq_vx = vx_s1 * vx_s1;
	assign sq_vy = vy_s1 * vy_s1;
	assign sq_ex = ex_s1 * ex_s1;
	assign sq_ey = ey_s1 * ey_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		degen_s2 <= (ex_s1 == '0) && (ey_s1 == '0);
		uex_s2   <= ux_s1 * ex_s1;
		uey_s2   <= uy_s1 * ey_s1;
		vex_s2   <= vx_s1 * ex_s1;
		vey_s2   <= vy_s1 * ey_s1;
		cxy_s2   <= ux_s1 * ey_s1;
		cyx_s2   <= uy_s1 * ex_s1;
		// squares of differences are below 2^(2*COORD_BITS)
		sux_s2   <= sq_ux[SQW-1:0];
		suy_s2   <= sq_uy[SQW-1:0];
		svx_s2   <= sq_vx[SQW-1:0];
		svy_s2   <= sq_vy[SQW-1:0];
		sex_s2   <= sq_ex[SQW-1:0];
		sey_s2   <= sq_ey[SQW-1:0];
	end

	// ---- stage 3: sign tests, region choice, |cross|
	logic                   vld_s3;
	logic [1:0]             region_s3;
	logic [CW-1:0]          cross_s3;
	logic [QW-1:0]          nsel_s3;
	logic [DW-1:0]          len2_s3;
	logic signed [DOTW-1:0] dot_u, dot_v, cross_c;
	logic [1:0]             region_c;

	assign dot_u   = DOTW'(uex_s2) + DOTW'(uey_s2);
	assign dot_v   = DOTW'(vex_s2) + DOTW'(vey_s2);
	assign cross_c = DOTW'(cxy_s2) - DOTW'(cyx_s2);

	always_comb begin
		if (degen_s2 || dot_u[DOTW-1]) begin
			region_c = REGION_START;
		end else if (!dot_v[DOTW-1] && (dot_v != '0)) begin
			// (P-B).(A-B) < 0 is (P-B).(B-A) > 0
			region_c = REGION_END;
		end else begin
			region_c = REGION_PERP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		region_s3 <= region_c;
		cross_s3  <= cross_c[DOTW-1] ? CW'(-cross_c) : CW'(cross_c);
		len2_s3   <= {1'b0, sex_s2} + {1'b0, sey_s2};
		if (region_c == REGION_START) begin
			nsel_s3 <= {1'b0, sux_s2} + {1'b0, suy_s2};
		end else begin
			nsel_s3 <= {1'b0, svx_s2} + {1'b0, svy_s2};
		end
	end

	// ---- stage 4: cross^2 as partial products
	logic              vld_s4;
	logic [1:0]        region_s4;
	logic [2*H-1:0]    ll_s4;
	logic [HW+H-1:0]   hl_s4;
	logic [2*HW-1:0]   hh_s4;
	logic [QW-1:0]     nsel_s4;
	logic [DW-1:0]     len2_s4;
	logic [H-1:0]      c_lo;
	logic [HW-1:0]     c_hi;

	assign c_lo = cross_s3[H-1:0];
	assign c_hi = cross_s3[CW-1:H];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		region_s4 <= region_s3;
		ll_s4     <= c_lo * c_lo;
		hl_s4     <= c_hi * c_lo;
		hh_s4     <= c_hi * c_hi;
		nsel_s4   <= nsel_s3;
		len2_s4   <= len2_s3;
	end

	// ---- stage 5: dividend and divisor (endpoints divide by one)
	logic          vld_s5;
	logic [1:0]    region_s5;
	logic [NW-1:0] num_s5;
	logic [DW-1:0] den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		region_s5 <= region_s4;
		if (region_s4 == REGION_PERP) begin
			num_s5 <= (NW'(hh_s4) << (2 * H)) + (NW'(hl_s4) << (H + 1)) + NW'(ll_s4);
			den_s5 <= len2_s4;
		end else begin
			num_s5 <= NW'(nsel_s4);
			den_s5 <= DW'(1);
		end
	end

	// ---- divider: one quotient bit per stage, quotient below 2^QW
	logic          div_vld_s [0:QW];
	logic [1:0]    div_reg_s [0:QW];
	logic [NW-1:0] div_rem_s [0:QW];
	logic [DW-1:0] div_den_s [0:QW];
	logic [QW-1:0] div_quo_s [0:QW];

	assign div_vld_s[0] = vld_s5;
	assign div_reg_s[0] = region_s5;
	assign div_rem_s[0] = num_s5;
	assign div_den_s[0] = den_s5;
	assign div_quo_s[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int K = QW - 1 - i;
		logic [NW-1:0] trial;
		logic          fits;

		assign trial = NW'(div_den_s[i]) << K;
		assign fits  = div_rem_s[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[i+1] <= 1'b0;
			end else begin
				div_vld_s[i+1] <= div_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			div_reg_s[i+1] <= div_reg_s[i];
			div_den_s[i+1] <= div_den_s[i];
			if (fits) begin
				div_rem_s[i+1] <= div_rem_s[i] - trial;
				div_quo_s[i+1] <= div_quo_s[i] | (QW'(1) << K);
			end else begin
				div_rem_s[i+1] <= div_rem_s[i];
				div_quo_s[i+1] <= div_quo_s[i];
			end
		end
	end

	// ---- square root: one root bit per stage, residue kept as q - root^2
	logic          sq_vld_s  [0:RW];
	logic [1:0]    sq_reg_s  [0:RW];
	logic [QW-1:0] sq_res_s  [0:RW];
	logic [RW-1:0] sq_root_s [0:RW];

	assign sq_vld_s[0]  = div_vld_s[QW];
	assign sq_reg_s[0]  = div_reg_s[QW];
	assign sq_res_s[0]  = div_quo_s[QW];
	assign sq_root_s[0] = '0;

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		localparam int B = RW - 1 - j;
		logic [TW-1:0] step;
		logic          take;

		// (r + 2^B)^2 - r^2
		assign step = (TW'(sq_root_s[j]) << (B + 1)) + (TW'(1) << (2 * B));
		assign take = {1'b0, sq_res_s[j]} >= step;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j+1] <= 1'b0;
			end else begin
				sq_vld_s[j+1] <= sq_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sq_reg_s[j+1] <= sq_reg_s[j];
			if (take) begin
				sq_res_s[j+1]  <= QW'({1'b0, sq_res_s[j]} - step);
				sq_root_s[j+1] <= sq_root_s[j] | (RW'(1) << B);
			end else begin
				sq_res_s[j+1]  <= sq_res_s[j];
				sq_root_s[j+1] <= sq_root_s[j];
			end
		end
	end

	assign strobe   = sq_vld_s[RW];
	assign distance = sq_root_s[RW];
	assign region   = sq_reg_s[RW];

	// ---- checks
	`PSD_ASSERT_IMPL(a_result_has_item, strobe, $past(start, LAT), "result without an item")
	`PSD_ASSERT_IMPL(a_endpoint_unit_div, strobe && (region != REGION_PERP), $past(den_s5 == DW'(1), QW + RW), "endpoint item divided by non-unit")
	`PSD_ASSERT_ALWAYS(a_region_code, !strobe || (region <= REGION_PERP), "region code out of range")

endmodule

`default_nettype wire
